FILE: design/bhph_pkg.sv
// Shared types, constants and codes for the beam histogram pruning heap.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package bhph_pkg;

   // Store geometry
   localparam int CAPACITY = 256;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int FILL_W   = $clog2(CAPACITY + 1);

   // Field widths
   localparam int KEY_W   = 32;
   localparam int SCORE_W = 32;
   localparam int TAG_W   = 32;
   localparam int BW_W    = 31;
   localparam int LIMIT_W = 9;
   localparam int CSR_W   = 31;

   localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
   localparam logic [BW_W-1:0]    BEAM_WIDTH_RST  = BW_W'(655360);
   localparam logic [LIMIT_W-1:0] ENTRY_LIMIT_RST = LIMIT_W'(256);

   // Operation codes
   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_POP    = 2'd2;

   // Register indexes
   localparam logic REG_BEAM_WIDTH  = 1'b0;
   localparam logic REG_ENTRY_LIMIT = 1'b1;

   // Result status codes
   localparam logic [2:0] ST_INSERTED  = 3'd0;
   localparam logic [2:0] ST_REPLACED  = 3'd1;
   localparam logic [2:0] ST_REJ_FULL  = 3'd2;
   localparam logic [2:0] ST_REJ_NOREP = 3'd3;
   localparam logic [2:0] ST_REJ_BEAM  = 3'd4;
   localparam logic [2:0] ST_POPPED    = 3'd5;
   localparam logic [2:0] ST_EMPTY     = 3'd6;
   localparam logic [2:0] ST_CLEARED   = 3'd7;

   // Store write data select
   localparam logic [1:0] WR_REQ  = 2'd0;
   localparam logic [1:0] WR_CUR  = 2'd1;
   localparam logic [1:0] WR_PICK = 2'd2;
   localparam logic [1:0] WR_RD   = 2'd3;

   // Moving entry load select
   localparam logic CUR_REQ = 1'b0;
   localparam logic CUR_RD  = 1'b1;

   typedef struct packed {
      logic [KEY_W-1:0]          key;
      logic signed [SCORE_W-1:0] score;
      logic [TAG_W-1:0]          tag;
   } entry_type;

   // Controller to datapath
   typedef struct packed {
      logic              load_req;
      logic              clear_best;
      logic              upd_best;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [1:0]        wr_sel;
      logic              cur_ld;
      logic              cur_sel;
      logic              cha_ld;
      logic              rsp_en;
      logic [2:0]        rsp_status;
      logic              rsp_pop;
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic beam_rej;
      logic key_eq;
      logic gt_rd;
      logic pick_b;
      logic child_lt;
      logic parent_gt;
      logic root_lt;
   } dp_stat_type;

endpackage

FILE: design/beam_histogram_pruning_heap_core.sv
// Top level: configuration registers, controller and datapath of the pruning heap.
// Depends on bhph_pkg, bhph_ctrl and bhph_datapath.
//
//   channel   ports                         handshake
//   request   start, busy, req_*            beat taken when start and not busy
//   result    rsp_valid, rsp_*              one-cycle strobe, cannot be held off
//   config    csr_valid, csr_ready, csr_*   beat taken when valid and ready
//
// Clear, pop and beam reject need no scan of the store. An insert scans held
// entries one by one for the key; a heap sift reads the children of each level
// and a bubble-up the parent of each level, all bound by the single read port of
// the store. The first insert into a full store also builds the heap (fill/2 sifts).
// Results never stall; a new request only waits for busy to drop.
// Reset is synchronous; the store needs no clearing pass.
`timescale 1ns / 1ps

module beam_histogram_pruning_heap_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_operation,
   input  logic [bhph_pkg::KEY_W-1:0]          req_hyp_key,
   input  logic signed [bhph_pkg::SCORE_W-1:0] req_hyp_score,
   input  logic [bhph_pkg::TAG_W-1:0]          req_hyp_tag,
   output logic                                rsp_valid,
   output logic [2:0]                          rsp_status,
   output logic [bhph_pkg::KEY_W-1:0]          rsp_out_key,
   output logic signed [bhph_pkg::SCORE_W-1:0] rsp_out_score,
   output logic [bhph_pkg::TAG_W-1:0]          rsp_out_tag,
   output logic [bhph_pkg::FILL_W-1:0]         rsp_fill_level,
   output logic signed [bhph_pkg::SCORE_W-1:0] rsp_top_score,
   output logic signed [bhph_pkg::SCORE_W-1:0] rsp_floor_score,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic                                csr_index,
   input  logic [bhph_pkg::CSR_W-1:0]          csr_wdata
);

   logic [bhph_pkg::BW_W-1:0]    beam_width_ff;
   logic [bhph_pkg::LIMIT_W-1:0] entry_limit_ff;
   bhph_pkg::ctl_cmd_type        cmd;
   bhph_pkg::dp_stat_type        stat;

   assign csr_ready = 1'b1;

   // Take configuration beats
   always_ff @(posedge clock) begin
      if (reset) begin
         beam_width_ff  <= bhph_pkg::BEAM_WIDTH_RST;
         entry_limit_ff <= bhph_pkg::ENTRY_LIMIT_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bhph_pkg::REG_BEAM_WIDTH:  beam_width_ff  <= csr_wdata[bhph_pkg::BW_W-1:0];
            bhph_pkg::REG_ENTRY_LIMIT: entry_limit_ff <= csr_wdata[bhph_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   bhph_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .entry_limit   (entry_limit_ff),
      .stat          (stat),
      .cmd           (cmd),
      .busy          (busy),
      .fill_level    (rsp_fill_level)
   );

   bhph_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_hyp_key     (req_hyp_key),
      .req_hyp_score   (req_hyp_score),
      .req_hyp_tag     (req_hyp_tag),
      .beam_width      (beam_width_ff),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_out_key     (rsp_out_key),
      .rsp_out_score   (rsp_out_score),
      .rsp_out_tag     (rsp_out_tag),
      .rsp_top_score   (rsp_top_score),
      .rsp_floor_score (rsp_floor_score)
   );

   // A result beat only appears once the block has gone idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // An accepted request makes the block busy
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy");

   // Fill never exceeds the store capacity
   a_fill_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_fill_level <= bhph_pkg::FILL_W'(bhph_pkg::CAPACITY))
      else $error("fill level above capacity");

   // Non-pop results carry a zero payload
   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != bhph_pkg::ST_POPPED)) |->
      ((rsp_out_key == '0) && (rsp_out_tag == '0) && (rsp_out_score == '0)))
      else $error("payload on non-pop result");

endmodule

FILE: design/bhph_datapath.sv
// Datapath: hypothesis store memory, request, moving-entry and result registers.
// Depends on bhph_pkg; driven by bhph_ctrl through command and status structs.
`timescale 1ns / 1ps

module bhph_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bhph_pkg::ctl_cmd_type                cmd,
   output bhph_pkg::dp_stat_type                stat,
   input  logic [bhph_pkg::KEY_W-1:0]           req_hyp_key,
   input  logic signed [bhph_pkg::SCORE_W-1:0]  req_hyp_score,
   input  logic [bhph_pkg::TAG_W-1:0]           req_hyp_tag,
   input  logic [bhph_pkg::BW_W-1:0]            beam_width,
   output logic                                 rsp_valid,
   output logic [2:0]                           rsp_status,
   output logic [bhph_pkg::KEY_W-1:0]           rsp_out_key,
   output logic signed [bhph_pkg::SCORE_W-1:0]  rsp_out_score,
   output logic [bhph_pkg::TAG_W-1:0]           rsp_out_tag,
   output logic signed [bhph_pkg::SCORE_W-1:0]  rsp_top_score,
   output logic signed [bhph_pkg::SCORE_W-1:0]  rsp_floor_score
);

   bhph_pkg::entry_type mem [bhph_pkg::CAPACITY];

   bhph_pkg::entry_type req_ff, cur_ff, cha_ff, rd_ff, rsp_ff;
   bhph_pkg::entry_type pick, wr_data;
   logic signed [bhph_pkg::SCORE_W-1:0] best_ff, best_in, floor_ff, floor_in;
   logic signed [bhph_pkg::SCORE_W:0]   floor_wide;
   logic                                rsp_valid_ff;
   logic [2:0]                          rsp_status_ff;

   // Compare flags for the controller
   // With only one child, rd_ff still holds that child, so pick_b stays low
   always_comb begin
      stat.beam_rej  = $signed(req_ff.score) < $signed(floor_ff);
      stat.key_eq    = rd_ff.key == req_ff.key;
      stat.gt_rd     = $signed(req_ff.score) > $signed(rd_ff.score);
      stat.pick_b    = $signed(rd_ff.score) < $signed(cha_ff.score);
      pick           = stat.pick_b ? rd_ff : cha_ff;
      stat.child_lt  = $signed(pick.score) < $signed(cur_ff.score);
      stat.parent_gt = $signed(rd_ff.score) > $signed(cur_ff.score);
      stat.root_lt   = $signed(rd_ff.score) < $signed(req_ff.score);
   end

   // Select store write data
   always_comb begin
      case (cmd.wr_sel)
         bhph_pkg::WR_REQ:  wr_data = req_ff;
         bhph_pkg::WR_CUR:  wr_data = cur_ff;
         bhph_pkg::WR_PICK: wr_data = pick;
         default:           wr_data = rd_ff;
      endcase
   end

   // Raise best score and saturated floor
   always_comb begin
      floor_wide = {req_ff.score[bhph_pkg::SCORE_W-1], req_ff.score}
                   - $signed({2'b00, beam_width});
      best_in  = best_ff;
      floor_in = floor_ff;
      if (cmd.clear_best) begin
         best_in  = bhph_pkg::SCORE_MIN;
         floor_in = bhph_pkg::SCORE_MIN;
      end else if (cmd.upd_best && ($signed(req_ff.score) > $signed(best_ff))) begin
         best_in = req_ff.score;
         if (floor_wide[bhph_pkg::SCORE_W] != floor_wide[bhph_pkg::SCORE_W-1]) begin
            floor_in = bhph_pkg::SCORE_MIN;
         end else begin
            floor_in = floor_wide[bhph_pkg::SCORE_W-1:0];
         end
      end
   end

   // Store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[cmd.rd_addr];
      end
   end

   // Hold request, moving entry, first child and result payload
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= '{key: req_hyp_key, score: req_hyp_score, tag: req_hyp_tag};
      end
      if (cmd.cur_ld) begin
         cur_ff <= (cmd.cur_sel == bhph_pkg::CUR_RD) ? rd_ff : req_ff;
      end
      if (cmd.cha_ld) begin
         cha_ff <= rd_ff;
      end
      if (cmd.rsp_en) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_ff        <= cmd.rsp_pop ? rd_ff : '0;
      end
   end

   // Control state: scores and result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff      <= bhph_pkg::SCORE_MIN;
         floor_ff     <= bhph_pkg::SCORE_MIN;
         rsp_valid_ff <= 1'b0;
      end else begin
         best_ff      <= best_in;
         floor_ff     <= floor_in;
         rsp_valid_ff <= cmd.rsp_en;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_key     = rsp_ff.key;
   assign rsp_out_score   = rsp_ff.score;
   assign rsp_out_tag     = rsp_ff.tag;
   assign rsp_top_score   = best_ff;
   assign rsp_floor_score = floor_ff;

endmodule

FILE: design/bhph_ctrl.sv
// Controller: sequences search, heap build, sift-down, bubble-up, evict and pop.
// Depends on bhph_pkg; commands bhph_datapath and owns fill count and heap flag.
`timescale 1ns / 1ps

module bhph_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [1:0]                         req_operation,
   input  logic [bhph_pkg::LIMIT_W-1:0]       entry_limit,
   input  bhph_pkg::dp_stat_type              stat,
   output bhph_pkg::ctl_cmd_type              cmd,
   output logic                               busy,
   output logic [bhph_pkg::FILL_W-1:0]        fill_level
);

   localparam int AW = bhph_pkg::ADDR_W;
   localparam int FW = bhph_pkg::FILL_W;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DISP     = 4'd1;
   localparam logic [3:0] S_POP      = 4'd2;
   localparam logic [3:0] S_SRCH_RD  = 4'd3;
   localparam logic [3:0] S_SRCH_CMP = 4'd4;
   localparam logic [3:0] S_BLD_RD   = 4'd5;
   localparam logic [3:0] S_BLD_LD   = 4'd6;
   localparam logic [3:0] S_SIFT_CHK = 4'd7;
   localparam logic [3:0] S_SIFT_A   = 4'd8;
   localparam logic [3:0] S_SIFT_DEC = 4'd9;
   localparam logic [3:0] S_BUB_RD   = 4'd10;
   localparam logic [3:0] S_BUB_DEC  = 4'd11;
   localparam logic [3:0] S_EV_RD    = 4'd12;
   localparam logic [3:0] S_EV_CHK   = 4'd13;
   localparam logic [3:0] S_EV_LD    = 4'd14;

   localparam logic [1:0] M_REPLACE = 2'd0;
   localparam logic [1:0] M_BUILD   = 2'd1;
   localparam logic [1:0] M_EVICT   = 2'd2;

   logic [3:0]    state_ff, state_in;
   logic [1:0]    op_ff, op_in, mode_ff, mode_in;
   logic [FW-1:0] fill_ff, fill_in, lim;
   logic          heap_ff, heap_in;
   logic [AW-1:0] idx_ff, idx_in, pos_ff, pos_in, par;
   logic [AW:0]   c1, c2;
   logic          nomatch, sift_fin, bub_fin;

   // Clamp the entry limit to 1..CAPACITY
   always_comb begin
      lim = FW'(entry_limit);
      if (entry_limit == '0) begin
         lim = FW'(1);
      end else if (FW'(entry_limit) > FW'(bhph_pkg::CAPACITY)) begin
         lim = FW'(bhph_pkg::CAPACITY);
      end
   end

   // Child and parent slots of the current position
   assign c1  = {pos_ff, 1'b1};
   assign c2  = c1 + 1'b1;
   assign par = (pos_ff - 1'b1) >> 1;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      mode_in  = mode_ff;
      fill_in  = fill_ff;
      heap_in  = heap_ff;
      idx_in   = idx_ff;
      pos_in   = pos_ff;
      cmd      = '0;
      nomatch  = 1'b0;
      sift_fin = 1'b0;
      bub_fin  = 1'b0;
      cmd.load_req = start && (state_ff == S_IDLE);

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = req_operation;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            case (op_ff)
               bhph_pkg::OP_CLEAR: begin
                  fill_in        = '0;
                  heap_in        = 1'b0;
                  cmd.clear_best = 1'b1;
                  cmd.rsp_en     = 1'b1;
                  cmd.rsp_status = bhph_pkg::ST_CLEARED;
                  state_in       = S_IDLE;
               end
               bhph_pkg::OP_INSERT: begin
                  if (stat.beam_rej) begin
                     cmd.rsp_en     = 1'b1;
                     cmd.rsp_status = bhph_pkg::ST_REJ_BEAM;
                     state_in       = S_IDLE;
                  end else begin
                     cmd.upd_best = 1'b1;
                     if (fill_ff == '0) begin
                        nomatch = 1'b1;
                     end else begin
                        idx_in   = '0;
                        state_in = S_SRCH_RD;
                     end
                  end
               end
               bhph_pkg::OP_POP: begin
                  if (fill_ff != '0) begin
                     fill_in     = fill_ff - 1'b1;
                     cmd.rd_en   = 1'b1;
                     cmd.rd_addr = AW'(fill_ff - 1'b1);
                     state_in    = S_POP;
                  end else begin
                     cmd.rsp_en     = 1'b1;
                     cmd.rsp_status = bhph_pkg::ST_EMPTY;
                     state_in       = S_IDLE;
                  end
               end
               default: begin
                  cmd.rsp_en     = 1'b1;
                  cmd.rsp_status = bhph_pkg::ST_EMPTY;
                  state_in       = S_IDLE;
               end
            endcase
         end
         S_POP: begin
            cmd.rsp_en     = 1'b1;
            cmd.rsp_pop    = 1'b1;
            cmd.rsp_status = bhph_pkg::ST_POPPED;
            state_in       = S_IDLE;
         end
         S_SRCH_RD: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = idx_ff;
            state_in    = S_SRCH_CMP;
         end
         S_SRCH_CMP: begin
            if (stat.key_eq) begin
               if (!stat.gt_rd) begin
                  cmd.rsp_en     = 1'b1;
                  cmd.rsp_status = bhph_pkg::ST_REJ_NOREP;
                  state_in       = S_IDLE;
               end else if (heap_ff) begin
                  cmd.cur_ld  = 1'b1;
                  cmd.cur_sel = bhph_pkg::CUR_REQ;
                  pos_in      = idx_ff;
                  mode_in     = M_REPLACE;
                  state_in    = S_SIFT_CHK;
               end else begin
                  cmd.wr_en      = 1'b1;
                  cmd.wr_addr    = idx_ff;
                  cmd.wr_sel     = bhph_pkg::WR_REQ;
                  cmd.rsp_en     = 1'b1;
                  cmd.rsp_status = bhph_pkg::ST_REPLACED;
                  state_in       = S_IDLE;
               end
            end else if ({1'b0, idx_ff} + 1'b1 == fill_ff) begin
               nomatch = 1'b1;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_SRCH_RD;
            end
         end
         S_BLD_RD: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = idx_ff;
            pos_in      = idx_ff;
            state_in    = S_BLD_LD;
         end
         S_BLD_LD: begin
            cmd.cur_ld  = 1'b1;
            cmd.cur_sel = bhph_pkg::CUR_RD;
            mode_in     = M_BUILD;
            state_in    = S_SIFT_CHK;
         end
         S_SIFT_CHK: begin
            if (c1 < fill_ff) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = c1[AW-1:0];
               state_in    = S_SIFT_A;
            end else begin
               cmd.wr_en   = 1'b1;
               cmd.wr_addr = pos_ff;
               cmd.wr_sel  = bhph_pkg::WR_CUR;
               sift_fin    = 1'b1;
            end
         end
         S_SIFT_A: begin
            cmd.cha_ld = 1'b1;
            if (c2 < fill_ff) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = c2[AW-1:0];
            end
            state_in = S_SIFT_DEC;
         end
         S_SIFT_DEC: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = pos_ff;
            if (stat.child_lt) begin
               cmd.wr_sel = bhph_pkg::WR_PICK;
               pos_in     = stat.pick_b ? c2[AW-1:0] : c1[AW-1:0];
               state_in   = S_SIFT_CHK;
            end else begin
               cmd.wr_sel = bhph_pkg::WR_CUR;
               sift_fin   = 1'b1;
            end
         end
         S_BUB_RD: begin
            if (pos_ff == '0) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_addr = pos_ff;
               cmd.wr_sel  = bhph_pkg::WR_CUR;
               bub_fin     = 1'b1;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = par;
               state_in    = S_BUB_DEC;
            end
         end
         S_BUB_DEC: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = pos_ff;
            if (stat.parent_gt) begin
               cmd.wr_sel = bhph_pkg::WR_RD;
               pos_in     = par;
               state_in   = S_BUB_RD;
            end else begin
               cmd.wr_sel = bhph_pkg::WR_CUR;
               bub_fin    = 1'b1;
            end
         end
         S_EV_RD: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = '0;
            state_in    = S_EV_CHK;
         end
         S_EV_CHK: begin
            if ((fill_ff == '0) || !stat.root_lt) begin
               cmd.rsp_en     = 1'b1;
               cmd.rsp_status = bhph_pkg::ST_REJ_FULL;
               state_in       = S_IDLE;
            end else begin
               fill_in     = fill_ff - 1'b1;
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = AW'(fill_ff - 1'b1);
               pos_in      = '0;
               state_in    = S_EV_LD;
            end
         end
         S_EV_LD: begin
            cmd.cur_ld  = 1'b1;
            cmd.cur_sel = bhph_pkg::CUR_RD;
            mode_in     = M_EVICT;
            state_in    = S_SIFT_CHK;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // No held entry has the key: append, or go down the full-store path
      if (nomatch) begin
         if (fill_ff < lim) begin
            cmd.cur_ld  = 1'b1;
            cmd.cur_sel = bhph_pkg::CUR_REQ;
            pos_in      = AW'(fill_ff);
            fill_in     = fill_ff + 1'b1;
            if (heap_ff) begin
               state_in = S_BUB_RD;
            end else begin
               cmd.wr_en      = 1'b1;
               cmd.wr_addr    = AW'(fill_ff);
               cmd.wr_sel     = bhph_pkg::WR_REQ;
               cmd.rsp_en     = 1'b1;
               cmd.rsp_status = bhph_pkg::ST_INSERTED;
               state_in       = S_IDLE;
            end
         end else if (!heap_ff) begin
            heap_in = 1'b1;
            if (fill_ff[FW-1:1] == '0) begin
               state_in = S_EV_RD;
            end else begin
               idx_in   = AW'(fill_ff[FW-1:1] - 1'b1);
               state_in = S_BLD_RD;
            end
         end else begin
            state_in = S_EV_RD;
         end
      end

      // Sift-down finished: continue by mode
      if (sift_fin) begin
         case (mode_ff)
            M_REPLACE: begin
               cmd.rsp_en     = 1'b1;
               cmd.rsp_status = bhph_pkg::ST_REPLACED;
               state_in       = S_IDLE;
            end
            M_BUILD: begin
               if (idx_ff == '0) begin
                  state_in = S_EV_RD;
               end else begin
                  idx_in   = idx_ff - 1'b1;
                  state_in = S_BLD_RD;
               end
            end
            default: begin
               cmd.cur_ld  = 1'b1;
               cmd.cur_sel = bhph_pkg::CUR_REQ;
               pos_in      = AW'(fill_ff);
               fill_in     = fill_ff + 1'b1;
               state_in    = S_BUB_RD;
            end
         endcase
      end

      // Bubble-up finished: the new entry is placed
      if (bub_fin) begin
         cmd.rsp_en     = 1'b1;
         cmd.rsp_status = bhph_pkg::ST_INSERTED;
         state_in       = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
         heap_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         heap_ff  <= heap_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      mode_ff  <= mode_in;
      idx_ff   <= idx_in;
      pos_ff   <= pos_in;
   end

   assign busy       = state_ff != S_IDLE;
   assign fill_level = fill_ff;

endmodule

FILE: bench/tb_beam_histogram_pruning_heap_core.sv
// Testbench for beam_histogram_pruning_heap_core: directed and random insert,
// pop and clear traffic checked against a behavioral store model in a scoreboard.
// Depends on bhph_pkg and the beam_histogram_pruning_heap_core RTL.
`timescale 1ns / 1ps

module tb_beam_histogram_pruning_heap_core;
   import bhph_pkg::*;

   localparam int IDLE_LIMIT = 40000;
   localparam int SETTLE     = 40;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [2:0]        status;
      logic [KEY_W-1:0]  key;
      logic [31:0]       score;
      logic [TAG_W-1:0]  tag;
      logic [FILL_W-1:0] fill;
      logic [31:0]       top;
      logic [31:0]       flr;
   } outcome_type;

   // Store model plus queue of pending outcomes
   class heap_scoreboard;
      int unsigned   beam_width;
      int unsigned   entry_limit;
      logic [31:0]   keys [CAPACITY];
      int            scores [CAPACITY];
      logic [31:0]   tags [CAPACITY];
      int unsigned   fill;
      bit            heaped;
      int            best;
      int            flr;
      outcome_type   pending [$];
      int            errors;

      function new();
         beam_width  = 32'(BEAM_WIDTH_RST);
         entry_limit = 32'(ENTRY_LIMIT_RST);
         fill = 0; heaped = 0; errors = 0;
         best = SCORE_MIN; flr = SCORE_MIN;
      endfunction

      function void set_reg(logic idx, logic [CSR_W-1:0] data);
         if (idx == REG_BEAM_WIDTH) beam_width = 32'(data);
         else entry_limit = 32'(data[LIMIT_W-1:0]);
      endfunction

      function void swap_slots(int unsigned a, int unsigned b);
         logic [31:0] k;
         logic [31:0] t;
         int          s;
         k = keys[a]; s = scores[a]; t = tags[a];
         keys[a] = keys[b]; scores[a] = scores[b]; tags[a] = tags[b];
         keys[b] = k; scores[b] = s; tags[b] = t;
      endfunction

      function void sift_down(int unsigned pos);
         int unsigned c;
         while (2 * pos + 1 < fill) begin
            c = 2 * pos + 1;
            if (c + 1 < fill && scores[c+1] < scores[c]) c++;
            if (scores[c] < scores[pos]) begin
               swap_slots(c, pos);
               pos = c;
            end else break;
         end
      endfunction

      function void bubble_up(int unsigned pos);
         int unsigned par;
         while (pos > 0) begin
            par = (pos - 1) / 2;
            if (scores[par] > scores[pos]) begin
               swap_slots(par, pos);
               pos = par;
            end else break;
         end
      endfunction

      function void place(int unsigned slot, logic [31:0] k, int s, logic [31:0] t);
         keys[slot] = k; scores[slot] = s; tags[slot] = t;
      endfunction

      function logic [2:0] insert_hyp(logic [31:0] k, int s, logic [31:0] t);
         longint      f;
         int unsigned lim;
         if (s < flr) return ST_REJ_BEAM;
         if (s > best) begin
            f = longint'(s) - longint'(beam_width);
            best = s;
            flr = (f < longint'(SCORE_MIN)) ? SCORE_MIN : int'(f);
         end
         // recombine with a held entry of the same key
         for (int unsigned i = 0; i < fill; i++) begin
            if (keys[i] == k) begin
               if (s > scores[i]) begin
                  scores[i] = s;
                  tags[i] = t;
                  if (heaped) sift_down(i);
                  return ST_REPLACED;
               end
               return ST_REJ_NOREP;
            end
         end
         lim = entry_limit;
         if (lim < 1) lim = 1;
         if (lim > CAPACITY) lim = CAPACITY;
         if (fill < lim) begin
            place(fill, k, s, t);
            fill++;
            if (heaped) bubble_up(fill - 1);
            return ST_INSERTED;
         end
         if (!heaped) begin
            for (int i = fill / 2; i > 0; i--) sift_down(i - 1);
            heaped = 1;
         end
         if (fill == 0 || !(scores[0] < s)) return ST_REJ_FULL;
         // evict the root, then append the newcomer
         fill--;
         place(0, keys[fill], scores[fill], tags[fill]);
         sift_down(0);
         place(fill, k, s, t);
         fill++;
         bubble_up(fill - 1);
         return ST_INSERTED;
      endfunction

      function void note_request(logic [1:0] op, logic [31:0] k, logic [31:0] s,
                                 logic [31:0] t);
         outcome_type o;
         o.status = ST_EMPTY; o.key = '0; o.score = '0; o.tag = '0;
         case (op)
            OP_CLEAR: begin
               fill = 0; heaped = 0; best = SCORE_MIN; flr = SCORE_MIN;
               o.status = ST_CLEARED;
            end
            OP_INSERT: o.status = insert_hyp(k, int'(s), t);
            OP_POP: begin
               if (fill > 0) begin
                  fill--;
                  o.key = keys[fill]; o.score = scores[fill]; o.tag = tags[fill];
                  o.status = ST_POPPED;
               end
            end
            default: ;
         endcase
         o.fill = FILL_W'(fill); o.top = best; o.flr = flr;
         pending.push_back(o);
      endfunction

      function void check_result(outcome_type got);
         outcome_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result, status %0d", $time, got.status);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.status !== e.status) report("status", 32'(e.status), 32'(got.status));
         if (got.key !== e.key) report("out_key", e.key, got.key);
         if (got.score !== e.score) report("out_score", e.score, got.score);
         if (got.tag !== e.tag) report("out_tag", e.tag, got.tag);
         if (got.fill !== e.fill) report("fill_level", 32'(e.fill), 32'(got.fill));
         if (got.top !== e.top) report("top_score", e.top, got.top);
         if (got.flr !== e.flr) report("floor_score", e.flr, got.flr);
      endfunction

      function void report(string field, logic [31:0] exp_v, logic [31:0] act_v);
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_v, act_v);
         errors++;
      endfunction
   endclass

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 start = 0;
   logic                 busy;
   logic [1:0]           req_operation = OP_CLEAR;
   logic [KEY_W-1:0]     req_hyp_key = '0;
   logic signed [31:0]   req_hyp_score = '0;
   logic [TAG_W-1:0]     req_hyp_tag = '0;
   logic                 rsp_valid;
   logic [2:0]           rsp_status;
   logic [KEY_W-1:0]     rsp_out_key;
   logic signed [31:0]   rsp_out_score;
   logic [TAG_W-1:0]     rsp_out_tag;
   logic [FILL_W-1:0]    rsp_fill_level;
   logic signed [31:0]   rsp_top_score;
   logic signed [31:0]   rsp_floor_score;
   logic                 csr_valid = 0;
   logic                 csr_ready;
   logic                 csr_index = REG_BEAM_WIDTH;
   logic [CSR_W-1:0]     csr_wdata = '0;

   heap_scoreboard sb = new();
   int             idle_cycles = 0;
   int             burst_left = 0;
   int             score_base = 0;
   int             score_spread = 1 << 21;

   beam_histogram_pruning_heap_core dut (.*);

   always #5 clock = ~clock;

   // Check each result strobe against the oldest pending outcome
   always @(posedge clock) begin
      outcome_type got;
      if (!reset && rsp_valid) begin
         got.status = rsp_status; got.key = rsp_out_key; got.score = rsp_out_score;
         got.tag = rsp_out_tag; got.fill = rsp_fill_level;
         got.top = rsp_top_score; got.flr = rsp_floor_score;
         sb.check_result(got);
      end
   end

   // Watchdog on cycles with no beat on any channel
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("beam_histogram_pruning_heap_core test failed");
         $finish;
      end
   end

   // Drive one request beat; gaps fall between bursts
   task automatic send_req(logic [1:0] op, logic [31:0] k, logic [31:0] s, logic [31:0] t);
      req_operation <= op; req_hyp_key <= k; req_hyp_score <= s; req_hyp_tag <= t;
      start <= 1;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_request(op, k, s, t);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         if ($urandom_range(0, 3) != 0) begin
            start <= 0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   endtask

   // Hold off requests until every result is back and the block has settled
   task automatic drain();
      start <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0 || busy !== 1'b0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [CSR_W-1:0] data);
      drain();
      csr_index <= idx; csr_wdata <= data; csr_valid <= 1;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.set_reg(idx, data);
      csr_valid <= 0;
   endtask

   function automatic logic [31:0] pick_score();
      if ($urandom_range(0, 9) == 0) return $urandom;
      return score_base + $urandom_range(0, 2 * score_spread) - score_spread;
   endfunction

   // Random traffic: mostly inserts on a small key pool, with pops and rare clears
   task automatic random_phase(int n, int pool, int ins_pct);
      int unsigned roll;
      logic [31:0] salt;
      logic [31:0] k;
      salt = $urandom;
      for (int i = 0; i < n; i++) begin
         roll = $urandom_range(0, 99);
         k = ($urandom_range(0, 9) == 0) ? $urandom : salt ^ $urandom_range(0, pool - 1);
         if (roll < ins_pct)
            send_req(OP_INSERT, k, pick_score(), $urandom);
         else if (roll < 96)
            send_req(OP_POP, $urandom, $urandom, $urandom);
         else if (roll < 98)
            send_req(OP_CLEAR, $urandom, $urandom, $urandom);
         else
            send_req(OP_UNUSED, $urandom, $urandom, $urandom);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: empty pop, unused code, extremes, recombination, beam reject
      send_req(OP_POP, 32'h0, 32'h0, 32'h0);
      send_req(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_req(OP_INSERT, 32'h0, 32'h8000_0000, 32'h0);
      send_req(OP_INSERT, 32'hFFFF_FFFF, 32'h8000_0005, 32'hFFFF_FFFF);
      send_req(OP_INSERT, 32'h1234_5678, 32'h7FFF_FFFF, 32'hA5A5_5A5A);
      send_req(OP_INSERT, 32'h0, 32'h0000_0000, 32'h1);
      send_req(OP_INSERT, 32'h1234_5678, 32'h7FFF_0000, 32'h2);
      send_req(OP_INSERT, 32'h1234_5678, 32'h7FFF_FFFF, 32'h3);
      send_req(OP_INSERT, 32'h5555_AAAA, 32'h7FF5_FFFF, 32'h4);
      send_req(OP_INSERT, 32'h5555_AAAA, 32'h7FF6_0000, 32'h5);
      send_req(OP_POP, 32'h0, 32'h0, 32'h0);
      send_req(OP_POP, 32'h0, 32'h0, 32'h0);
      send_req(OP_CLEAR, 32'h0, 32'h0, 32'h0);
      send_req(OP_POP, 32'h0, 32'h0, 32'h0);
      // floor saturates near the most negative score
      send_req(OP_INSERT, 32'h77, 32'h8000_0010, 32'h6);
      send_req(OP_INSERT, 32'h78, 32'h8000_0000, 32'h7);

      // Limit of zero acts as one; widest beam
      write_reg(REG_ENTRY_LIMIT, CSR_W'(0));
      write_reg(REG_BEAM_WIDTH, 31'h7FFF_FFFF);
      send_req(OP_CLEAR, 0, 0, 0);
      send_req(OP_INSERT, 32'h10, 32'h0001_0000, 32'h10);
      send_req(OP_INSERT, 32'h11, 32'h0000_8000, 32'h11);
      send_req(OP_INSERT, 32'h12, 32'h0002_0000, 32'h12);
      send_req(OP_INSERT, 32'h12, 32'h0003_0000, 32'h13);
      send_req(OP_POP, 0, 0, 0);

      // Random phases across settings
      write_reg(REG_ENTRY_LIMIT, CSR_W'(8));
      write_reg(REG_BEAM_WIDTH, CSR_W'(655360));
      random_phase(120, 16, 75);

      write_reg(REG_BEAM_WIDTH, CSR_W'(0));
      write_reg(REG_ENTRY_LIMIT, CSR_W'(1));
      score_spread = 1 << 16;
      random_phase(60, 4, 75);

      write_reg(REG_BEAM_WIDTH, 31'h7FFF_FFFF);
      write_reg(REG_ENTRY_LIMIT, CSR_W'(32));
      score_spread = 1 << 24;
      random_phase(110, 64, 88);

      // Lower the limit below the fill level without clearing
      write_reg(REG_ENTRY_LIMIT, CSR_W'(4));
      random_phase(60, 64, 90);

      // Above capacity acts as capacity: fill the whole store
      write_reg(REG_ENTRY_LIMIT, CSR_W'(9'h1FF));
      write_reg(REG_BEAM_WIDTH, 31'h0100_0000);
      send_req(OP_CLEAR, 0, 0, 0);
      score_spread = 1 << 22;
      random_phase(300, 4096, 97);

      write_reg(REG_ENTRY_LIMIT, CSR_W'(12));
      write_reg(REG_BEAM_WIDTH, CSR_W'(1 << 18));
      score_base = -(1 << 30);
      score_spread = 1 << 19;
      random_phase(100, 24, 72);

      drain();
      if (sb.pending.size() != 0) sb.errors++;
      if (sb.errors == 0)
         $display("beam_histogram_pruning_heap_core test passed");
      else
         $display("beam_histogram_pruning_heap_core test failed");
      $finish;
   end
endmodule
